// ===== hw/rtl/pfbb_pkg.sv =====
// Shared types for the page framebuffer bitmap blit block.
// Holds the command codes and the control and status records between
// the controller and the datapath. No dependencies.
package pfbb_pkg;

  typedef enum logic [1:0] {
    CMD_CLEAR = 2'd0,
    CMD_BLIT  = 2'd1,
    CMD_READ  = 2'd2,
    CMD_NOP   = 2'd3
  } pfbb_cmd_t;

  typedef struct packed {
    logic load_item;
    logic rd_lo;
    logic rd_hi;
    logic wr_lo;
    logic wr_hi;
    logic sweep_wr;
    logic load_out;
  } pfbb_ctrl_t;

  typedef struct packed {
    pfbb_cmd_t cmd;
    logic      clip;
    logic      read_ok;
    logic      spill;
    logic      sweep_last;
  } pfbb_status_t;

endpackage

// ===== hw/rtl/pfbb_req_if.sv =====
// Request channel of the page framebuffer bitmap blit block.
// Carries valid, ready and the request fields. No dependencies.
interface pfbb_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] cmd;
  logic [8:0] col;
  logic [7:0] row;
  logic [4:0] page_offset;
  logic [7:0] pixels;

  modport source (output valid, output cmd, output col, output row,
                  output page_offset, output pixels, input ready);
  modport sink (input valid, input cmd, input col, input row,
                input page_offset, input pixels, output ready);
endinterface

// ===== hw/rtl/pfbb_rsp_if.sv =====
// Result channel of the page framebuffer bitmap blit block.
// Carries valid, ready and the result fields. No dependencies.
interface pfbb_rsp_if;
  logic       valid;
  logic       ready;
  logic [7:0] read_data;
  logic       clipped;

  modport source (output valid, output read_data, output clipped, input ready);
  modport sink (input valid, input read_data, input clipped, output ready);
endinterface

// ===== hw/rtl/page_framebuffer_bitmap_blit.sv =====
// Page framebuffer bitmap blit: top level joining controller and datapath.
// Depends on pfbb_pkg, pfbb_req_if, pfbb_rsp_if, pfbb_ctrl, pfbb_datapath.
//
// The block keeps a monochrome frame store of PAGE_COUNT pages by
// COLUMN_COUNT columns in one RAM with a registered read port; each byte
// holds eight vertical pixels, bit 0 on top. Requests are taken one at a
// time and every request gives exactly one result. A blit goes from decode
// to modify to finish, with a further state that writes the upper byte
// when its bits spill into the next page; the read-modify-write of each
// touched byte goes through the single read and single write port of the
// store. A read or a clipped or unknown request goes from decode straight
// to finish. A clear writes one entry per cycle over the whole store
// (1024 entries at the default size). The block is ready for the next
// request in the cycle after the result is loaded. After reset the same
// sweep runs, with no result, before the first request is accepted. A new
// request is accepted while an earlier result still waits in the output register.
module page_framebuffer_bitmap_blit #(
  parameter int PAGE_COUNT   = 8,
  parameter int COLUMN_COUNT = 128
) (
  input  logic              clk,
  input  logic              rst_n,
  pfbb_req_if.sink          in_chan,
  pfbb_rsp_if.source        out_chan
);
  import pfbb_pkg::*;

  pfbb_ctrl_t   ctrl;
  pfbb_status_t status;
  logic         in_ready;
  logic         out_valid;
  logic [7:0]   read_data;
  logic         clipped;

  pfbb_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_chan.ready),
    .status    (status),
    .ctrl      (ctrl)
  );

  pfbb_datapath #(
    .PAGE_COUNT   (PAGE_COUNT),
    .COLUMN_COUNT (COLUMN_COUNT)
  ) u_datapath (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_cmd         (in_chan.cmd),
    .in_col         (in_chan.col),
    .in_row         (in_chan.row),
    .in_page_offset (in_chan.page_offset),
    .in_pixels      (in_chan.pixels),
    .ctrl           (ctrl),
    .status         (status),
    .out_read_data  (read_data),
    .out_clipped    (clipped)
  );

  assign in_chan.ready      = in_ready;
  assign out_chan.valid     = out_valid;
  assign out_chan.read_data = read_data;
  assign out_chan.clipped   = clipped;

endmodule

// ===== hw/rtl/pfbb_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module pfbb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== hw/rtl/pfbb_ctrl.sv =====
// Controller state machine of the page framebuffer bitmap blit block.
// Depends on pfbb_pkg for the control and status records.
module pfbb_ctrl (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  output logic                   out_valid,
  input  logic                   out_ready,
  input  pfbb_pkg::pfbb_status_t status,
  output pfbb_pkg::pfbb_ctrl_t   ctrl
);
  import pfbb_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_DECODE = 6'b000010,
    S_MODIFY = 6'b000100,
    S_WR_HI  = 6'b001000,
    S_CLEAR  = 6'b010000,
    S_FINISH = 6'b100000
  } state_t;

  state_t state_r, state_nxt;
  logic   clr_item_r, clr_item_nxt;
  logic   out_valid_r, out_valid_nxt;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt    = state_r;
    clr_item_nxt = clr_item_r;
    ctrl         = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          ctrl.load_item = 1'b1;
          state_nxt      = S_DECODE;
        end
      end
      S_DECODE: begin
        case (status.cmd)
          CMD_CLEAR: begin
            clr_item_nxt = 1'b1;
            state_nxt    = S_CLEAR;
          end
          CMD_BLIT: begin
            if (status.clip) begin
              state_nxt = S_FINISH;
            end else begin
              ctrl.rd_lo = 1'b1;
              state_nxt  = S_MODIFY;
            end
          end
          CMD_READ: begin
            ctrl.rd_lo = status.read_ok;
            state_nxt  = S_FINISH;
          end
          default: begin
            state_nxt = S_FINISH;
          end
        endcase
      end
      S_MODIFY: begin
        ctrl.wr_lo = 1'b1;
        ctrl.rd_hi = status.spill;
        state_nxt  = status.spill ? S_WR_HI : S_FINISH;
      end
      S_WR_HI: begin
        ctrl.wr_hi = 1'b1;
        state_nxt  = S_FINISH;
      end
      S_CLEAR: begin
        ctrl.sweep_wr = 1'b1;
        if (status.sweep_last) begin
          clr_item_nxt = 1'b0;
          state_nxt    = clr_item_r ? S_FINISH : S_IDLE;
        end
      end
      S_FINISH: begin
        if (!out_valid_r || out_ready) begin
          ctrl.load_out = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    if (ctrl.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_item_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_item_r  <= clr_item_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

`ifndef SYNTH
  a_load_out_free: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.load_out |-> (!out_valid_r || out_ready))
    else $error("result loaded over an unread result");

  a_one_writer: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({ctrl.wr_lo, ctrl.wr_hi, ctrl.sweep_wr}))
    else $error("more than one store write source");

  a_hi_after_lo: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WR_HI) |-> $past(state_r == S_MODIFY))
    else $error("spill write without a preceding base write");

  a_sweep_end: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLEAR && status.sweep_last) |=>
      (state_r == S_IDLE || state_r == S_FINISH))
    else $error("clear sweep did not end");
`endif

endmodule

// ===== hw/rtl/pfbb_datapath.sv =====
// Datapath of the page framebuffer bitmap blit block: request registers,
// address and bounds logic, read-modify-write merge, clear sweep counter,
// frame store and result register. Depends on pfbb_pkg and pfbb_ram.
module pfbb_datapath #(
  parameter int PAGE_COUNT   = 8,
  parameter int COLUMN_COUNT = 128
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic [1:0]             in_cmd,
  input  logic [8:0]             in_col,
  input  logic [7:0]             in_row,
  input  logic [4:0]             in_page_offset,
  input  logic [7:0]             in_pixels,
  input  pfbb_pkg::pfbb_ctrl_t   ctrl,
  output pfbb_pkg::pfbb_status_t status,
  output logic [7:0]             out_read_data,
  output logic                   out_clipped
);
  import pfbb_pkg::*;

  localparam int PW     = (PAGE_COUNT > 1) ? $clog2(PAGE_COUNT) : 1;
  localparam int CW     = $clog2(COLUMN_COUNT);
  localparam int ADDR_W = PW + CW;
  localparam int DEPTH  = 2 ** ADDR_W;

  pfbb_cmd_t         cmd_r;
  logic [8:0]        col_r;
  logic [7:0]        row_r;
  logic [4:0]        poff_r;
  logic [7:0]        pix_r;
  logic [ADDR_W-1:0] sweep_r;
  logic [7:0]        read_data_r;
  logic              clipped_r;

  logic [5:0]        page;
  logic [5:0]        page_hi;
  logic [2:0]        shift;
  logic [15:0]       shifted;
  logic              row_oob, col_oob, page_oob;
  logic [CW-1:0]     col_idx;
  logic [ADDR_W-1:0] addr_lo, addr_hi, addr_rd;
  logic              ram_rd_en, ram_wr_en;
  logic [ADDR_W-1:0] ram_rd_addr, ram_wr_addr;
  logic [7:0]        ram_wr_data, ram_rd_data;

  always_ff @(posedge clk) begin
    if (ctrl.load_item) begin
      cmd_r  <= pfbb_cmd_t'(in_cmd);
      col_r  <= in_col;
      row_r  <= in_row;
      poff_r <= in_page_offset;
      pix_r  <= in_pixels;
    end
  end

  assign page     = {1'b0, row_r[7:3]} + {1'b0, poff_r};
  assign page_hi  = page + 6'd1;
  assign shift    = row_r[2:0];
  assign shifted  = {8'd0, pix_r} << shift;
  assign row_oob  = {1'b0, row_r} >= 9'(PAGE_COUNT * 8);
  assign col_oob  = {2'b00, col_r} >= 11'(COLUMN_COUNT);
  assign page_oob = page >= 6'(PAGE_COUNT);
  assign col_idx  = CW'(col_r);

  assign addr_lo = {PW'(page), col_idx};
  assign addr_hi = {PW'(page_hi), col_idx};
  assign addr_rd = {PW'(poff_r), col_idx};

  assign status.cmd        = cmd_r;
  assign status.clip       = row_oob || col_oob || page_oob;
  assign status.read_ok    = !col_oob && ({1'b0, poff_r} < 6'(PAGE_COUNT));
  assign status.spill      = (shift != 3'd0) && (page_hi < 6'(PAGE_COUNT));
  assign status.sweep_last = &sweep_r;

  assign ram_rd_en   = ctrl.rd_lo || ctrl.rd_hi;
  assign ram_rd_addr = ctrl.rd_hi ? addr_hi : ((cmd_r == CMD_READ) ? addr_rd : addr_lo);
  assign ram_wr_en   = ctrl.sweep_wr || ctrl.wr_lo || ctrl.wr_hi;

  always_comb begin
    if (ctrl.sweep_wr) begin
      ram_wr_addr = sweep_r;
      ram_wr_data = 8'h00;
    end else if (ctrl.wr_lo) begin
      ram_wr_addr = addr_lo;
      ram_wr_data = ram_rd_data | shifted[7:0];
    end else begin
      ram_wr_addr = addr_hi;
      ram_wr_data = ram_rd_data | shifted[15:8];
    end
  end

  pfbb_ram #(
    .WIDTH (8),
    .DEPTH (DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sweep_r <= '0;
    end else if (ctrl.sweep_wr) begin
      sweep_r <= sweep_r + ADDR_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load_out) begin
      read_data_r <= (cmd_r == CMD_READ && status.read_ok) ? ram_rd_data : 8'h00;
      clipped_r   <= (cmd_r == CMD_BLIT) && status.clip;
    end
  end

  assign out_read_data = read_data_r;
  assign out_clipped   = clipped_r;

endmodule
